@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the commit ring queue.
// Each macro checks a property on the rising edge of clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the property holds at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the condition never occurs at a clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/ppcrq_pkg.sv @@
// Package for the ping-pong commit ring queue: sizes, codes and payload structs.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package ppcrq_pkg;

    localparam int DEPTH    = 256;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = PTR_W + 1;
    localparam int IDX_W    = PTR_W + 1;
    localparam int LEVEL_W  = 8;
    localparam int DATA_W   = 32;
    localparam int CFG_W    = 9;

    localparam logic [CFG_W-1:0] CAPACITY_RESET       = CFG_W'(DEPTH);
    localparam logic [CFG_W-1:0] SWITCH_ADVANCE_RESET = CFG_W'(10);

    typedef enum logic [1:0] {
        CMD_RESERVE = 2'd0,
        CMD_CONFIRM = 2'd1,
        CMD_POP     = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        CFG_CAPACITY       = 1'b0,
        CFG_SWITCH_ADVANCE = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [LEVEL_W-1:0] entry_level;
        logic               bank;
        logic [7:0]         slot;
        logic [DATA_W-1:0]  entry_data;
    } request_t;

    typedef struct packed {
        status_t            status;
        logic               out_bank;
        logic [7:0]         out_slot;
        logic [LEVEL_W-1:0] out_level;
        logic [DATA_W-1:0]  out_data;
        logic               swapped;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/ping_pong_commit_ring_queue.sv @@
// Ping-pong commit ring queue: two ring banks with reserve, confirm and pop commands.
// Depends on ppcrq_pkg and assert_macros.svh.
// The result strobe (done) is registered and rises in the cycle after the command is accepted.
// Throughput: one command per cycle while busy is low; pointers, fill counts and ready bits are flip-flops.
// Level and payload words sit in two 512-entry memories with a registered read port.
// Reset clears pointers, fill counts, ready bits and bank roles; busy is high for one cycle.
// The receiver cannot stall: every result is on the ports for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ping_pong_commit_ring_queue (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire ppcrq_pkg::request_t             request,
    output logic                                 done,
    output ppcrq_pkg::result_t                   result,
    input  wire logic                            cfg_we,
    input  wire ppcrq_pkg::cfg_index_t           cfg_index,
    input  wire logic [ppcrq_pkg::CFG_W-1:0]     cfg_data
);
    import ppcrq_pkg::*;

    function automatic logic [PTR_W-1:0] advance_ptr(input logic [PTR_W-1:0] p,
                                                     input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] n;
        n = {1'b0, p} + CNT_W'(1);
        return (n >= cap) ? '0 : n[PTR_W-1:0];
    endfunction

    // Configuration and control state.
    logic [CFG_W-1:0]   capacity_reg;
    logic [CFG_W-1:0]   advance_reg;
    logic               cur_bank_reg, cur_bank_next;
    logic [PTR_W-1:0]   wp_reg [2];
    logic [PTR_W-1:0]   wp_next [2];
    logic [PTR_W-1:0]   rp_reg [2];
    logic [PTR_W-1:0]   rp_next [2];
    logic [CNT_W-1:0]   fill_reg [2];
    logic [CNT_W-1:0]   fill_next [2];
    logic [DEPTH-1:0]   ready_reg [2];
    logic               busy_reg;

    // Result registers.
    logic               done_reg, done_next;
    status_t            status_reg, status_next;
    logic               bank_reg, bank_next;
    logic [7:0]         slot_reg, slot_next;
    logic               swapped_reg, swapped_next;
    logic               pop_ok_reg, pop_ok_next;

    // Entry stores.
    logic [LEVEL_W-1:0] level_mem [2*DEPTH];
    logic [DATA_W-1:0]  payload_mem [2*DEPTH];
    logic [LEVEL_W-1:0] level_rd_reg;
    logic [DATA_W-1:0]  payload_rd_reg;

    logic               accept;
    logic [CNT_W-1:0]   cap;
    logic               rsv_bank;
    logic               pop_bank;
    logic [IDX_W-1:0]   rd_idx;
    logic               level_we;
    logic [IDX_W-1:0]   level_idx;
    logic               payload_we;
    logic [IDX_W-1:0]   payload_idx;
    logic               rdy_we;
    logic               rdy_bank;
    logic [PTR_W-1:0]   rdy_slot;
    logic               rdy_val;
    logic [CNT_W:0]     margin_sum;

    assign accept = start && !busy_reg;

    always_comb
    begin
        if (capacity_reg == '0)
            cap = CNT_W'(1);
        else if (capacity_reg > CFG_W'(DEPTH))
            cap = CNT_W'(DEPTH);
        else
            cap = CNT_W'(capacity_reg);
    end

    assign rsv_bank   = cur_bank_reg;
    // Pop drains the backup bank first.
    assign pop_bank   = (fill_reg[~cur_bank_reg] != '0) ? ~cur_bank_reg : cur_bank_reg;
    assign rd_idx     = {pop_bank, rp_reg[pop_bank]};
    assign margin_sum = {1'b0, fill_reg[rsv_bank]} + {1'b0, CNT_W'(advance_reg)};

    always_comb
    begin
        cur_bank_next = cur_bank_reg;
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        fill_next     = fill_reg;
        done_next     = 1'b0;
        status_next   = STATUS_OK;
        bank_next     = 1'b0;
        slot_next     = '0;
        swapped_next  = 1'b0;
        pop_ok_next   = 1'b0;
        level_we      = 1'b0;
        level_idx     = {rsv_bank, wp_reg[rsv_bank]};
        payload_we    = 1'b0;
        payload_idx   = {request.bank, request.slot};
        rdy_we        = 1'b0;
        rdy_bank      = rsv_bank;
        rdy_slot      = wp_reg[rsv_bank];
        rdy_val       = 1'b0;

        if (accept)
        begin
            unique case (request.command)
                CMD_RESERVE:
                begin
                    done_next = 1'b1;
                    bank_next = rsv_bank;
                    slot_next = wp_reg[rsv_bank];
                    if (fill_reg[rsv_bank] >= cap)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        if (margin_sum >= {1'b0, cap} && fill_reg[~rsv_bank] == '0)
                        begin
                            cur_bank_next = ~rsv_bank;
                            swapped_next  = 1'b1;
                        end
                        level_we            = 1'b1;
                        rdy_we              = 1'b1;
                        wp_next[rsv_bank]   = advance_ptr(wp_reg[rsv_bank], cap);
                        fill_next[rsv_bank] = fill_reg[rsv_bank] + CNT_W'(1);
                    end
                end
                CMD_CONFIRM:
                begin
                    // The slot field cannot reach past the bank depth, so every
                    // confirm writes its slot.
                    done_next  = 1'b1;
                    bank_next  = request.bank;
                    slot_next  = request.slot;
                    payload_we = 1'b1;
                    rdy_we     = 1'b1;
                    rdy_bank   = request.bank;
                    rdy_slot   = request.slot;
                    rdy_val    = 1'b1;
                end
                CMD_POP:
                begin
                    done_next = 1'b1;
                    if (fill_reg[pop_bank] == '0 || !ready_reg[pop_bank][rp_reg[pop_bank]])
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        bank_next           = pop_bank;
                        slot_next           = rp_reg[pop_bank];
                        pop_ok_next         = 1'b1;
                        rdy_we              = 1'b1;
                        rdy_bank            = pop_bank;
                        rdy_slot            = rp_reg[pop_bank];
                        rp_next[pop_bank]   = advance_ptr(rp_reg[pop_bank], cap);
                        fill_next[pop_bank] = fill_reg[pop_bank] - CNT_W'(1);
                    end
                end
                default:
                begin
                    done_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
            advance_reg  <= SWITCH_ADVANCE_RESET;
            cur_bank_reg <= 1'b0;
            busy_reg     <= 1'b1;
            done_reg     <= 1'b0;
            for (int b = 0; b < 2; b++)
            begin
                wp_reg[b]    <= '0;
                rp_reg[b]    <= '0;
                fill_reg[b]  <= '0;
                ready_reg[b] <= '0;
            end
        end
        else
        begin
            busy_reg     <= 1'b0;
            cur_bank_reg <= cur_bank_next;
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            fill_reg     <= fill_next;
            done_reg     <= done_next;
            if (rdy_we)
                ready_reg[rdy_bank][rdy_slot] <= rdy_val;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CAPACITY:       capacity_reg <= cfg_data;
                    CFG_SWITCH_ADVANCE: advance_reg  <= cfg_data;
                    default:            capacity_reg <= capacity_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        bank_reg    <= bank_next;
        slot_reg    <= slot_next;
        swapped_reg <= swapped_next;
        pop_ok_reg  <= pop_ok_next;
    end

    always_ff @(posedge clk)
    begin
        if (level_we)
            level_mem[level_idx] <= request.entry_level;
        level_rd_reg <= level_mem[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (payload_we)
            payload_mem[payload_idx] <= request.entry_data;
        payload_rd_reg <= payload_mem[rd_idx];
    end

    assign busy             = busy_reg;
    assign done             = done_reg;
    assign result.status    = status_reg;
    assign result.out_bank  = bank_reg;
    assign result.out_slot  = slot_reg;
    assign result.out_level = pop_ok_reg ? level_rd_reg : '0;
    assign result.out_data  = pop_ok_reg ? payload_rd_reg : '0;
    assign result.swapped   = swapped_reg;

    `ASSERT_CLK(a_done_follows_accept, done |-> $past(accept), "result without a command")
    `ASSERT_CLK(a_swap_flips_bank, (done && result.swapped) |-> (cur_bank_reg != $past(cur_bank_reg)), "swap did not change the current bank")
    `ASSERT_CLK(a_pop_ok_no_swap, (done && pop_ok_reg) |-> (!result.swapped && result.status == STATUS_OK), "pop result carries wrong flags")
    `ASSERT_NEVER(a_fill_bound, (fill_reg[0] > CNT_W'(DEPTH)) || (fill_reg[1] > CNT_W'(DEPTH)), "fill count beyond bank depth")

endmodule

`default_nettype wire

@@ bench/tb_ping_pong_commit_ring_queue.sv @@
// Self-checking testbench for the ping-pong commit ring queue.
// Depends on ppcrq_pkg and the ping_pong_commit_ring_queue RTL; checks every
// result against a cycle-free model of the two ring banks kept in this file.
`timescale 1ns / 1ps

module tb_ping_pong_commit_ring_queue;
    import ppcrq_pkg::*;

    localparam int STALL_LIMIT = 2000;

    // Everything the two ring banks hold, plus the two configuration registers.
    typedef struct {
        logic [CFG_W-1:0]   capacity;
        logic [CFG_W-1:0]   advance;
        logic               cur;
        logic [PTR_W-1:0]   wp [2];
        logic [PTR_W-1:0]   rp [2];
        logic [CNT_W-1:0]   fill [2];
        logic [LEVEL_W-1:0] level [2*DEPTH];
        logic [DATA_W-1:0]  payload [2*DEPTH];
        logic               ready [2*DEPTH];
        logic               level_known [2*DEPTH];
    } ring_state_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    request_t request = '0;
    logic done;
    result_t result;
    logic cfg_we = 1'b0;
    cfg_index_t cfg_index = CFG_CAPACITY;
    logic [CFG_W-1:0] cfg_data = '0;

    ring_state_t dut_ring;
    ring_state_t plan_ring;
    request_t request_backlog [$];
    result_t outcome_queue [$];
    result_t fresh_outcome;
    logic fresh_valid = 1'b0;
    result_t accepted_outcome;
    logic accepted_valid;
    result_t oldest_outcome;
    int gap_left = 0;
    int burst_left = 0;
    int failures = 0;
    int stall_cycles = 0;

    logic [CFG_W-1:0] phase_cap [13] = '{9'd256, 9'd4, 9'd256, 9'd3, 9'd1, 9'd16, 9'd2,
                                         9'd511, 9'd0, 9'd8, 9'd100, 9'd5, 9'd0};
    logic [CFG_W-1:0] phase_adv [13] = '{9'd10, 9'd0, 9'd0, 9'd256, 9'd0, 9'd4, 9'd1,
                                         9'd511, 9'd300, 9'd7, 9'd256, 9'd2, 9'd0};
    int phase_len [13] = '{60, 70, 90, 60, 40, 80, 60, 60, 30, 70, 60, 60, 50};

    ping_pong_commit_ring_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void clear_ring(ref ring_state_t s);
        s.capacity = CAPACITY_RESET;
        s.advance = SWITCH_ADVANCE_RESET;
        s.cur = 1'b0;
        for (int b = 0; b < 2; b++)
        begin
            s.wp[b] = '0;
            s.rp[b] = '0;
            s.fill[b] = '0;
        end
        for (int i = 0; i < 2*DEPTH; i++)
        begin
            s.level[i] = '0;
            s.payload[i] = '0;
            s.ready[i] = 1'b0;
            s.level_known[i] = 1'b0;
        end
    endfunction

    // Pointers wrap once they reach or pass the effective capacity.
    function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p, logic [CFG_W-1:0] cap);
        logic [CFG_W-1:0] n;
        n = {1'b0, p} + CFG_W'(1);
        return (n >= cap) ? '0 : n[PTR_W-1:0];
    endfunction

    // Applies one command to the ring state; returns 1 when the command yields a result.
    function automatic bit apply_ring_command(ref ring_state_t s, input request_t req,
                                              output result_t res);
        logic [CFG_W-1:0] cap;
        logic [CFG_W:0]   margin;
        logic             b;
        logic             q;
        logic [IDX_W-1:0] idx;
        res = '0;
        cap = (s.capacity == '0) ? CFG_W'(1) :
              (s.capacity > CFG_W'(DEPTH)) ? CFG_W'(DEPTH) : s.capacity;
        case (req.command)
            CMD_RESERVE:
            begin
                b = s.cur;
                res.out_bank = b;
                res.out_slot = s.wp[b];
                if (s.fill[b] >= cap)
                begin
                    res.status = STATUS_FULL;
                    return 1'b1;
                end
                margin = {1'b0, s.fill[b]} + {1'b0, s.advance};
                if (margin >= {1'b0, cap} && s.fill[~b] == '0)
                begin
                    s.cur = ~b;
                    res.swapped = 1'b1;
                end
                idx = {b, s.wp[b]};
                s.level[idx] = req.entry_level;
                s.level_known[idx] = 1'b1;
                s.ready[idx] = 1'b0;
                s.wp[b] = next_ptr(s.wp[b], cap);
                s.fill[b] = s.fill[b] + CNT_W'(1);
                return 1'b1;
            end
            CMD_CONFIRM:
            begin
                res.out_bank = req.bank;
                res.out_slot = req.slot;
                idx = {req.bank, req.slot};
                s.payload[idx] = req.entry_data;
                s.ready[idx] = 1'b1;
                return 1'b1;
            end
            CMD_POP:
            begin
                // The backup bank drains first whenever it holds anything.
                q = (s.fill[~s.cur] != '0) ? ~s.cur : s.cur;
                idx = {q, s.rp[q]};
                if (s.fill[q] == '0 || !s.ready[idx])
                begin
                    res.status = STATUS_EMPTY;
                    return 1'b1;
                end
                s.ready[idx] = 1'b0;
                res.out_bank = q;
                res.out_slot = s.rp[q];
                res.out_level = s.level[idx];
                res.out_data = s.payload[idx];
                s.rp[q] = next_ptr(s.rp[q], cap);
                s.fill[q] = s.fill[q] - CNT_W'(1);
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Mostly short gaps, a few long ones, and now and then a run with no gaps at all.
    function automatic int idle_gap();
        int roll;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4)
        begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic report_failure(input string msg);
        $display("%0t ns: ERROR %s", $time, msg);
        failures++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            report_failure($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
    endtask

    // Driver: holds a command until it is accepted, then idles for a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            request <= '0;
            gap_left <= 0;
            fresh_valid <= 1'b0;
        end
        else
        begin
            accepted_valid = 1'b0;
            if (start && !busy)
                accepted_valid = apply_ring_command(dut_ring, request, accepted_outcome);
            fresh_valid <= accepted_valid;
            if (accepted_valid)
                fresh_outcome <= accepted_outcome;
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (request_backlog.size() != 0)
                begin
                    request <= request_backlog.pop_front();
                    start <= 1'b1;
                    gap_left <= idle_gap();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: the expectation registered by the driver at acceptance is queued
    // before the oldest expectation is compared, so the order within a step is fixed.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (fresh_valid)
                outcome_queue.push_back(fresh_outcome);
            if (done)
            begin
                if (outcome_queue.size() == 0)
                    report_failure("result strobe with no transaction outstanding");
                else
                begin
                    oldest_outcome = outcome_queue.pop_front();
                    check_field("status", 32'(oldest_outcome.status), 32'(result.status));
                    check_field("out_bank", 32'(oldest_outcome.out_bank),
                                32'(result.out_bank));
                    check_field("out_slot", 32'(oldest_outcome.out_slot),
                                32'(result.out_slot));
                    check_field("out_level", 32'(oldest_outcome.out_level),
                                32'(result.out_level));
                    check_field("out_data", oldest_outcome.out_data, result.out_data);
                    check_field("swapped", 32'(oldest_outcome.swapped),
                                32'(result.swapped));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("ping_pong_commit_ring_queue test failed");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_command(input cmd_t cmd, input logic [LEVEL_W-1:0] lvl,
                                 input logic bnk, input logic [7:0] slt,
                                 input logic [DATA_W-1:0] dat, output result_t outcome);
        request_t req;
        req.command = cmd;
        req.entry_level = lvl;
        req.bank = bnk;
        req.slot = slt;
        req.entry_data = dat;
        void'(apply_ring_command(plan_ring, req, outcome));
        request_backlog.push_back(req);
    endtask

    // Waits until every command is accepted and every result has arrived, then lets
    // an ignored command that may still be in flight settle.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_backlog.size() != 0 || start || fresh_valid ||
               outcome_queue.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure_ring(input logic [CFG_W-1:0] cap, input logic [CFG_W-1:0] adv);
        wait_drained();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_CAPACITY;
        cfg_data <= cap;
        @(posedge clk);
        cfg_index <= CFG_SWITCH_ADVANCE;
        cfg_data <= adv;
        @(posedge clk);
        cfg_we <= 1'b0;
        dut_ring.capacity = cap;
        dut_ring.advance = adv;
        plan_ring = dut_ring;
    endtask

    task automatic run_directed_checks();
        result_t r;
        result_t first_slot;
        result_t second_slot;
        queue_command(CMD_POP, 8'h00, 1'b0, 8'h00, 32'h0, r);
        queue_command(CMD_NONE, 8'hff, 1'b1, 8'hff, 32'hffff_ffff, r);
        queue_command(CMD_RESERVE, 8'hff, 1'b1, 8'hff, 32'hffff_ffff, first_slot);
        queue_command(CMD_RESERVE, 8'h00, 1'b0, 8'h00, 32'h0, second_slot);
        // Confirming out of order leaves the oldest entry unready, so the pop must miss.
        queue_command(CMD_CONFIRM, 8'h00, second_slot.out_bank, second_slot.out_slot,
                      32'h0, r);
        queue_command(CMD_POP, 8'h00, 1'b0, 8'h00, 32'h0, r);
        queue_command(CMD_CONFIRM, 8'h00, first_slot.out_bank, first_slot.out_slot,
                      32'hffff_ffff, r);
        queue_command(CMD_POP, 8'h00, 1'b0, 8'h00, 32'h0, r);
        queue_command(CMD_POP, 8'h00, 1'b0, 8'h00, 32'h0, r);
        queue_command(CMD_POP, 8'h00, 1'b0, 8'h00, 32'h0, r);
        // A confirm of a slot that is not reserved still sets its ready bit.
        queue_command(CMD_CONFIRM, 8'h00, 1'b0, 8'h00, 32'h5a5a_a5a5, r);
        queue_command(CMD_POP, 8'h00, 1'b0, 8'h00, 32'h0, r);
        // A reserve clears the ready bit of the slot it claims.
        queue_command(CMD_RESERVE, 8'h81, 1'b0, 8'h00, 32'h0, first_slot);
        queue_command(CMD_POP, 8'h00, 1'b0, 8'h00, 32'h0, r);
        queue_command(CMD_CONFIRM, 8'h00, first_slot.out_bank, first_slot.out_slot,
                      32'h8000_0001, r);
        queue_command(CMD_POP, 8'h00, 1'b0, 8'h00, 32'h0, r);

        // Capacity zero acts as one; the write pointer is beyond it and must wrap.
        configure_ring(9'd0, 9'd1);
        queue_command(CMD_RESERVE, 8'h3c, 1'b0, 8'h00, 32'h0, first_slot);
        queue_command(CMD_RESERVE, 8'hc3, 1'b0, 8'h00, 32'h0, second_slot);
        queue_command(CMD_RESERVE, 8'h11, 1'b0, 8'h00, 32'h0, r);
        queue_command(CMD_CONFIRM, 8'h00, second_slot.out_bank, second_slot.out_slot,
                      32'h1234_5678, r);
        queue_command(CMD_POP, 8'h00, 1'b0, 8'h00, 32'h0, r);
        queue_command(CMD_CONFIRM, 8'h00, first_slot.out_bank, first_slot.out_slot,
                      32'h8765_4321, r);
        queue_command(CMD_POP, 8'h00, 1'b0, 8'h00, 32'h0, r);
        queue_command(CMD_POP, 8'h00, 1'b0, 8'h00, 32'h0, r);
        queue_command(CMD_POP, 8'h00, 1'b0, 8'h00, 32'h0, r);

        // Register values above the bank depth.
        configure_ring(9'd511, 9'd511);
        queue_command(CMD_RESERVE, 8'h7e, 1'b0, 8'h00, 32'h0, first_slot);
        queue_command(CMD_CONFIRM, 8'h00, first_slot.out_bank, first_slot.out_slot,
                      32'hdead_beef, r);
        queue_command(CMD_POP, 8'h00, 1'b0, 8'h00, 32'h0, r);
    endtask

    // Mostly reserve, confirm, pop flows with random content; the rest is ignored
    // commands, confirms of stray slots and reservations that are never confirmed.
    task automatic run_random_traffic(input int count);
        result_t r;
        logic [IDX_W-1:0] open_slots [$];
        logic [IDX_W-1:0] target;
        logic [IDX_W-1:0] probe;
        int reserve_weight;
        int roll;
        int pick;
        int issued;
        bit found;
        reserve_weight = $urandom_range(20, 55);
        issued = 0;
        while (issued < count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
            begin
                queue_command(CMD_NONE, LEVEL_W'($urandom), 1'($urandom), 8'($urandom),
                              $urandom, r);
                continue;
            end
            if (roll < 3 + reserve_weight)
            begin
                queue_command(CMD_RESERVE, LEVEL_W'($urandom), 1'($urandom), 8'($urandom),
                              $urandom, r);
                if (r.status == STATUS_OK)
                    open_slots.push_back({r.out_bank, r.out_slot});
                if (open_slots.size() > 12)
                    void'(open_slots.pop_front());
            end
            else if (roll < 33 + reserve_weight && open_slots.size() != 0)
            begin
                pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, open_slots.size() - 1)
                                                   : 0;
                target = open_slots[pick];
                open_slots.delete(pick);
                queue_command(CMD_CONFIRM, LEVEL_W'($urandom), target[IDX_W-1],
                              target[PTR_W-1:0], $urandom, r);
            end
            else if (roll < 38 + reserve_weight)
            begin
                // Only slots whose level has been written since reset may become ready.
                found = 1'b0;
                for (int tries = 0; tries < 16 && !found; tries++)
                begin
                    probe = IDX_W'($urandom_range(0, 2*DEPTH - 1));
                    found = plan_ring.level_known[probe];
                end
                if (found)
                    queue_command(CMD_CONFIRM, LEVEL_W'($urandom), probe[IDX_W-1],
                                  probe[PTR_W-1:0], $urandom, r);
                else
                    queue_command(CMD_POP, LEVEL_W'($urandom), 1'($urandom), 8'($urandom),
                                  $urandom, r);
            end
            else
                queue_command(CMD_POP, LEVEL_W'($urandom), 1'($urandom), 8'($urandom),
                              $urandom, r);
            issued++;
        end
    endtask

    initial
    begin
        clear_ring(dut_ring);
        plan_ring = dut_ring;
        phase_cap[12] = CFG_W'($urandom_range(0, 511));
        phase_adv[12] = CFG_W'($urandom_range(0, 511));
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(negedge clk);
        while (busy);

        run_directed_checks();
        for (int p = 0; p < 13; p++)
        begin
            configure_ring(phase_cap[p], phase_adv[p]);
            run_random_traffic(phase_len[p]);
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (failures == 0)
            $display("ping_pong_commit_ring_queue test passed");
        else
            $display("ping_pong_commit_ring_queue test failed");
        $finish;
    end

endmodule

@@ ping_pong_commit_ring_queue.f @@
+incdir+rtl
rtl/ppcrq_pkg.sv
rtl/ping_pong_commit_ring_queue.sv
bench/tb_ping_pong_commit_ring_queue.sv
